@@ rtl/wrs_pkg.sv @@
// shared types and constants of the weighted running statistics block
// state machine codes, datapath operation codes, status group, fixed widths
// no dependencies
package wrs_pkg;

    localparam int WEIGHT_W   = 16;
    localparam int CRIT_W     = 16;
    localparam int WSUM_W     = 40;
    localparam int WSQ_W      = 56;
    localparam int DEV_W      = 64;
    localparam int VAR_W      = 48;
    localparam int SD_W       = 32;
    localparam int CV_W       = 32;
    localparam int HW_W       = 32;
    localparam int PROD_W     = 48;
    localparam int DIV_NUM_W  = 72;
    localparam int DIV_DEN_W  = 48;
    localparam int SQRT_ARG_W = 64;
    localparam int SQRT_RES_W = 32;

    localparam logic [CRIT_W-1:0] CRIT_RESET = 16'd502;
    localparam logic [WSUM_W-1:0] WSUM_ONE   = 40'd256;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_MEAN_DIV,
        ST_MEAN_WAIT,
        ST_MEAN_UPD,
        ST_DEV_MUL,
        ST_DEV_WAIT,
        ST_VAR_DIV,
        ST_VAR_WAIT,
        ST_QW_DIV,
        ST_QW_WAIT,
        ST_UNB_DIV,
        ST_UNB_WAIT,
        ST_SD_SQRT,
        ST_SD_WAIT,
        ST_CV_DIV,
        ST_CV_WAIT,
        ST_RT_SQRT,
        ST_RT_WAIT,
        ST_HW_MUL,
        ST_HW_DIV,
        ST_HW_WAIT,
        ST_PUBLISH
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP,
        OP_MEAN_DIV,
        OP_MEAN_UPD,
        OP_MUL_START,
        OP_DEV_UPD,
        OP_VAR_DIV,
        OP_VAR_WR,
        OP_QW_DIV,
        OP_QW_WR,
        OP_UNB_DIV,
        OP_UNB_WR,
        OP_SD_SQRT,
        OP_SD_WR,
        OP_CV_DIV,
        OP_CV_WR,
        OP_RT_SQRT,
        OP_RT_WR,
        OP_HW_MUL,
        OP_HW_DIV,
        OP_HW_WR,
        OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        logic is_clear;
        logic wsum_nz;
        logic wsum_gt_one;
        logic wsum_gt_q;
        logic mean_nz;
        logic count_nz;
        logic div_done;
        logic sqrt_done;
        logic mul_done;
        logic out_full;
    } dp_status_t;

endpackage

@@ rtl/wrs_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on wrs_pkg for operand widths
module wrs_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [wrs_pkg::DIV_NUM_W-1:0] num,
    input  logic [wrs_pkg::DIV_DEN_W-1:0] den,
    output logic                          done,
    output logic [wrs_pkg::DIV_NUM_W-1:0] quo
);

    localparam int NW    = wrs_pkg::DIV_NUM_W;
    localparam int DW    = wrs_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;

    logic [DW:0]      trial;
    logic             ge;
    logic [DW:0]      diff;
    logic [DW-1:0]    rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NW-1]};
        ge       = trial >= {1'b0, den_reg};
        diff     = trial - {1'b0, den_reg};
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

@@ rtl/wrs_sqrt.sv @@
// floor square root, one result bit per cycle
// depends on wrs_pkg for argument and result widths
module wrs_sqrt
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [wrs_pkg::SQRT_ARG_W-1:0] arg,
    output logic                           done,
    output logic [wrs_pkg::SQRT_RES_W-1:0] res
);

    localparam int AW    = wrs_pkg::SQRT_ARG_W;
    localparam int RW    = wrs_pkg::SQRT_RES_W;
    localparam int CNT_W = $clog2(RW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [AW-1:0]    v_reg;
    logic [AW-1:0]    res_reg;
    logic [AW-1:0]    bit_reg;

    logic [AW-1:0]    trial;
    logic             ge;

    always_comb
    begin
        trial = res_reg + bit_reg;
        ge    = v_reg >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(RW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= arg;
            res_reg <= '0;
            bit_reg <= AW'(1) << (AW - 2);
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign res  = res_reg[RW-1:0];

endmodule

@@ rtl/wrs_ctrl.sv @@
// sequencer of the statistics block: one operation code per cycle
// depends on wrs_pkg for state, operation and status types
module wrs_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  wrs_pkg::dp_status_t status,
    output wrs_pkg::dp_op_t     op
);

    wrs_pkg::ctrl_state_t state_reg;
    wrs_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wrs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = wrs_pkg::OP_NONE;
        unique case (state_reg)
            wrs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op         = wrs_pkg::OP_LOAD;
                    state_next = wrs_pkg::ST_PREP;
                end
            end
            wrs_pkg::ST_PREP:
            begin
                if (status.is_clear)
                begin
                    state_next = wrs_pkg::ST_VAR_DIV;
                end
                else
                begin
                    op         = wrs_pkg::OP_PREP;
                    state_next = wrs_pkg::ST_MEAN_DIV;
                end
            end
            wrs_pkg::ST_MEAN_DIV:
            begin
                if (status.wsum_nz)
                begin
                    op         = wrs_pkg::OP_MEAN_DIV;
                    state_next = wrs_pkg::ST_MEAN_WAIT;
                end
                else
                begin
                    state_next = wrs_pkg::ST_DEV_MUL;
                end
            end
            wrs_pkg::ST_MEAN_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = wrs_pkg::ST_MEAN_UPD;
                end
            end
            wrs_pkg::ST_MEAN_UPD:
            begin
                op         = wrs_pkg::OP_MEAN_UPD;
                state_next = wrs_pkg::ST_DEV_MUL;
            end
            wrs_pkg::ST_DEV_MUL:
            begin
                op         = wrs_pkg::OP_MUL_START;
                state_next = wrs_pkg::ST_DEV_WAIT;
            end
            wrs_pkg::ST_DEV_WAIT:
            begin
                if (status.mul_done)
                begin
                    op         = wrs_pkg::OP_DEV_UPD;
                    state_next = wrs_pkg::ST_VAR_DIV;
                end
            end
            wrs_pkg::ST_VAR_DIV:
            begin
                if (status.wsum_gt_one)
                begin
                    op         = wrs_pkg::OP_VAR_DIV;
                    state_next = wrs_pkg::ST_VAR_WAIT;
                end
                else
                begin
                    state_next = wrs_pkg::ST_QW_DIV;
                end
            end
            wrs_pkg::ST_VAR_WAIT:
            begin
                if (status.div_done)
                begin
                    op         = wrs_pkg::OP_VAR_WR;
                    state_next = wrs_pkg::ST_QW_DIV;
                end
            end
            wrs_pkg::ST_QW_DIV:
            begin
                if (status.wsum_nz)
                begin
                    op         = wrs_pkg::OP_QW_DIV;
                    state_next = wrs_pkg::ST_QW_WAIT;
                end
                else
                begin
                    state_next = wrs_pkg::ST_SD_SQRT;
                end
            end
            wrs_pkg::ST_QW_WAIT:
            begin
                if (status.div_done)
                begin
                    op         = wrs_pkg::OP_QW_WR;
                    state_next = wrs_pkg::ST_UNB_DIV;
                end
            end
            wrs_pkg::ST_UNB_DIV:
            begin
                if (status.wsum_gt_q)
                begin
                    op         = wrs_pkg::OP_UNB_DIV;
                    state_next = wrs_pkg::ST_UNB_WAIT;
                end
                else
                begin
                    state_next = wrs_pkg::ST_SD_SQRT;
                end
            end
            wrs_pkg::ST_UNB_WAIT:
            begin
                if (status.div_done)
                begin
                    op         = wrs_pkg::OP_UNB_WR;
                    state_next = wrs_pkg::ST_SD_SQRT;
                end
            end
            wrs_pkg::ST_SD_SQRT:
            begin
                op         = wrs_pkg::OP_SD_SQRT;
                state_next = wrs_pkg::ST_SD_WAIT;
            end
            wrs_pkg::ST_SD_WAIT:
            begin
                if (status.sqrt_done)
                begin
                    op         = wrs_pkg::OP_SD_WR;
                    state_next = wrs_pkg::ST_CV_DIV;
                end
            end
            wrs_pkg::ST_CV_DIV:
            begin
                if (status.mean_nz)
                begin
                    op         = wrs_pkg::OP_CV_DIV;
                    state_next = wrs_pkg::ST_CV_WAIT;
                end
                else
                begin
                    state_next = wrs_pkg::ST_RT_SQRT;
                end
            end
            wrs_pkg::ST_CV_WAIT:
            begin
                if (status.div_done)
                begin
                    op         = wrs_pkg::OP_CV_WR;
                    state_next = wrs_pkg::ST_RT_SQRT;
                end
            end
            wrs_pkg::ST_RT_SQRT:
            begin
                if (status.count_nz)
                begin
                    op         = wrs_pkg::OP_RT_SQRT;
                    state_next = wrs_pkg::ST_RT_WAIT;
                end
                else
                begin
                    state_next = wrs_pkg::ST_PUBLISH;
                end
            end
            wrs_pkg::ST_RT_WAIT:
            begin
                if (status.sqrt_done)
                begin
                    op         = wrs_pkg::OP_RT_WR;
                    state_next = wrs_pkg::ST_HW_MUL;
                end
            end
            wrs_pkg::ST_HW_MUL:
            begin
                op         = wrs_pkg::OP_HW_MUL;
                state_next = wrs_pkg::ST_HW_DIV;
            end
            wrs_pkg::ST_HW_DIV:
            begin
                op         = wrs_pkg::OP_HW_DIV;
                state_next = wrs_pkg::ST_HW_WAIT;
            end
            wrs_pkg::ST_HW_WAIT:
            begin
                if (status.div_done)
                begin
                    op         = wrs_pkg::OP_HW_WR;
                    state_next = wrs_pkg::ST_PUBLISH;
                end
            end
            wrs_pkg::ST_PUBLISH:
            begin
                if (!status.out_full)
                begin
                    op         = wrs_pkg::OP_PUBLISH;
                    state_next = wrs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wrs_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall = state_reg != wrs_pkg::ST_IDLE;

endmodule

@@ rtl/wrs_datapath.sv @@
// statistics state, operand selection, shift-add multiplier and output register
// depends on wrs_pkg, wrs_div and wrs_sqrt
module wrs_datapath
#(
    parameter int COUNT_WIDTH = 24,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  wrs_pkg::dp_op_t                     op,
    output wrs_pkg::dp_status_t                 status,
    input  logic                                cfg_write_enable,
    input  logic [wrs_pkg::CRIT_W-1:0]          cfg_write_data,
    input  logic                                command,
    input  logic signed [VALUE_WIDTH-1:0]       sample_value,
    input  logic [wrs_pkg::WEIGHT_W-1:0]        sample_weight,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [COUNT_WIDTH-1:0]              sample_count,
    output logic signed [VALUE_WIDTH-1:0]       min_value,
    output logic signed [VALUE_WIDTH-1:0]       max_value,
    output logic signed [VALUE_WIDTH-1:0]       mean_value,
    output logic [wrs_pkg::VAR_W-1:0]           variance_out,
    output logic [wrs_pkg::VAR_W-1:0]           unbiased_variance,
    output logic [wrs_pkg::SD_W-1:0]            std_deviation,
    output logic signed [wrs_pkg::CV_W-1:0]     variation_coef,
    output logic [wrs_pkg::HW_W-1:0]            half_width
);

    localparam int VW     = VALUE_WIDTH;
    localparam int CW     = COUNT_WIDTH;
    localparam int A_W    = VW + 1;
    localparam int U_W    = VW + 1 + wrs_pkg::WEIGHT_W;
    localparam int P_W    = U_W + A_W;
    localparam int PX_W   = (P_W > 89) ? P_W : 89;
    localparam int MCNT_W = $clog2(A_W + 1);
    localparam int NW     = wrs_pkg::DIV_NUM_W;
    localparam int DW     = wrs_pkg::DIV_DEN_W;

    localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

    // architectural statistics
    logic [wrs_pkg::CRIT_W-1:0] crit_reg;
    logic [CW-1:0]              count_reg;
    logic signed [VW-1:0]       min_reg;
    logic signed [VW-1:0]       max_reg;
    logic [wrs_pkg::WSUM_W-1:0] wsum_reg;
    logic [wrs_pkg::WSQ_W-1:0]  wsq_reg;
    logic signed [VW-1:0]       mean_reg;
    logic [wrs_pkg::DEV_W-1:0]  dev_reg;
    logic                       clear_reg;
    logic                       out_valid_reg;
    logic                       mbusy_reg;
    logic                       mdone_reg;
    logic [MCNT_W-1:0]          mcnt_reg;

    // per-request working registers
    logic signed [VW-1:0]         x_reg;
    logic [wrs_pkg::WEIGHT_W-1:0] w_reg;
    logic                         d1_neg_reg;
    logic                         d2_neg_reg;
    logic [A_W-1:0]               a_reg;
    logic [U_W-1:0]               u_reg;
    logic [P_W-1:0]               prod_reg;
    logic [wrs_pkg::VAR_W-1:0]    var_reg;
    logic [wrs_pkg::VAR_W-1:0]    unb_reg;
    logic [NW-1:0]                qw_reg;
    logic [wrs_pkg::SD_W-1:0]     sd_reg;
    logic [wrs_pkg::CV_W-1:0]     cv_reg;
    logic [wrs_pkg::SQRT_RES_W-1:0] root_reg;
    logic [wrs_pkg::PROD_W-1:0]   hp_reg;
    logic [wrs_pkg::HW_W-1:0]     hw_reg;

    // output register payload
    logic [CW-1:0]             o_count_reg;
    logic signed [VW-1:0]      o_min_reg;
    logic signed [VW-1:0]      o_max_reg;
    logic signed [VW-1:0]      o_mean_reg;
    logic [wrs_pkg::VAR_W-1:0] o_var_reg;
    logic [wrs_pkg::VAR_W-1:0] o_unb_reg;
    logic [wrs_pkg::SD_W-1:0]  o_sd_reg;
    logic [wrs_pkg::CV_W-1:0]  o_cv_reg;
    logic [wrs_pkg::HW_W-1:0]  o_hw_reg;

    // shared units
    logic                            div_start;
    logic [NW-1:0]                   div_num;
    logic [DW-1:0]                   div_den;
    logic                            div_done;
    logic [NW-1:0]                   div_quo;
    logic                            sqrt_start;
    logic [wrs_pkg::SQRT_ARG_W-1:0]  sqrt_arg;
    logic                            sqrt_done;
    logic [wrs_pkg::SQRT_RES_W-1:0]  sqrt_res;

    // combinational next values
    logic                        load_clear;
    logic [CW-1:0]               count_next;
    logic [wrs_pkg::WSUM_W:0]    wsum_sum;
    logic [wrs_pkg::WSUM_W-1:0]  wsum_next;
    logic [wrs_pkg::WSQ_W:0]     wsq_sum;
    logic [wrs_pkg::WSQ_W-1:0]   wsq_next;
    logic [VW:0]                 d1_next;
    logic [A_W-1:0]              a_next;
    logic [VW+1:0]               mean_ext;
    logic [VW+1:0]               delta_ext;
    logic [VW+1:0]               msum;
    logic                        msum_ovf;
    logic signed [VW-1:0]        mean_next;
    logic [VW:0]                 d2_next;
    logic [A_W-1:0]              b_next;
    logic [U_W:0]                mul_hi;
    logic [PX_W-1:0]             prod_x;
    logic [wrs_pkg::DEV_W-1:0]   term;
    logic [wrs_pkg::DEV_W:0]     dev_sum;
    logic [wrs_pkg::DEV_W-1:0]   dev_next;
    logic [wrs_pkg::VAR_W-1:0]   vq_next;
    logic [VW-1:0]               mean_mag;
    logic [NW-1:0]               cv_sat;
    logic [wrs_pkg::CV_W-1:0]    cv_next;
    logic [wrs_pkg::HW_W-1:0]    hw_next;

    wrs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    wrs_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .arg   (sqrt_arg),
        .done  (sqrt_done),
        .res   (sqrt_res)
    );

    // load step: counters, extremes, weight sums and the first deviation
    always_comb
    begin
        load_clear = command == wrs_pkg::CMD_CLEAR;
        count_next = (count_reg != {CW{1'b1}}) ? count_reg + 1'b1 : count_reg;
        wsum_sum   = (wrs_pkg::WSUM_W+1)'(wsum_reg) + (wrs_pkg::WSUM_W+1)'(sample_weight);
        wsum_next  = wsum_sum[wrs_pkg::WSUM_W] ? {wrs_pkg::WSUM_W{1'b1}}
                                               : wsum_sum[wrs_pkg::WSUM_W-1:0];
        wsq_sum    = (wrs_pkg::WSQ_W+1)'(wsq_reg)
                   + (wrs_pkg::WSQ_W+1)'(sample_weight * sample_weight);
        wsq_next   = wsq_sum[wrs_pkg::WSQ_W] ? {wrs_pkg::WSQ_W{1'b1}}
                                             : wsq_sum[wrs_pkg::WSQ_W-1:0];
        d1_next    = {sample_value[VW-1], sample_value} - {mean_reg[VW-1], mean_reg};
        a_next     = d1_next[VW] ? A_W'(~d1_next + 1'b1) : A_W'(d1_next);
    end

    // mean step: the quotient never exceeds the deviation magnitude
    always_comb
    begin
        mean_ext  = {{2{mean_reg[VW-1]}}, mean_reg};
        delta_ext = {1'b0, div_quo[A_W-1:0]};
        msum      = d1_neg_reg ? mean_ext - delta_ext : mean_ext + delta_ext;
        msum_ovf  = !((msum[VW+1:VW-1] == 3'b000) || (msum[VW+1:VW-1] == 3'b111));
        if (msum_ovf)
        begin
            mean_next = msum[VW+1] ? VAL_MIN : VAL_MAX;
        end
        else
        begin
            mean_next = msum[VW-1:0];
        end
        d2_next = {x_reg[VW-1], x_reg} - {mean_reg[VW-1], mean_reg};
        b_next  = d2_next[VW] ? A_W'(~d2_next + 1'b1) : A_W'(d2_next);
    end

    // deviation step: product scaled down by 24 bits, sign of the two deviations
    always_comb
    begin
        mul_hi  = (U_W+1)'(prod_reg[P_W-1:A_W]) + (prod_reg[0] ? (U_W+1)'(u_reg) : '0);
        prod_x  = PX_W'(prod_reg);
        term    = (|prod_x[PX_W-1:88]) ? {wrs_pkg::DEV_W{1'b1}} : prod_x[87:24];
        dev_sum = (wrs_pkg::DEV_W+1)'(dev_reg) + (wrs_pkg::DEV_W+1)'(term);
        if ((d1_neg_reg != d2_neg_reg) && (term != '0))
        begin
            dev_next = (dev_reg > term) ? dev_reg - term : '0;
        end
        else
        begin
            dev_next = dev_sum[wrs_pkg::DEV_W] ? {wrs_pkg::DEV_W{1'b1}}
                                               : dev_sum[wrs_pkg::DEV_W-1:0];
        end
    end

    // result steps
    always_comb
    begin
        vq_next  = (|div_quo[NW-1:wrs_pkg::VAR_W]) ? {wrs_pkg::VAR_W{1'b1}}
                                                   : div_quo[wrs_pkg::VAR_W-1:0];
        mean_mag = mean_reg[VW-1] ? VW'(~mean_reg + 1'b1) : VW'(mean_reg);
        if (!mean_reg[VW-1])
        begin
            cv_next = (|div_quo[NW-1:31]) ? 32'h7FFF_FFFF : div_quo[31:0];
            cv_sat  = '0;
        end
        else
        begin
            if ((|div_quo[NW-1:32]) || (div_quo[31] && (|div_quo[30:0])))
            begin
                cv_sat = NW'(33'h0_8000_0000);
            end
            else
            begin
                cv_sat = div_quo;
            end
            cv_next = wrs_pkg::CV_W'(~cv_sat[31:0] + 1'b1);
        end
        hw_next = (|div_quo[NW-1:wrs_pkg::HW_W]) ? {wrs_pkg::HW_W{1'b1}}
                                                 : div_quo[wrs_pkg::HW_W-1:0];
    end

    // operand selection for the shared divider and square root
    always_comb
    begin
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        sqrt_start = 1'b0;
        sqrt_arg   = '0;
        case (op) inside
            wrs_pkg::OP_MEAN_DIV:
            begin
                div_start = 1'b1;
                div_num   = NW'(u_reg);
                div_den   = DW'(wsum_reg);
            end
            wrs_pkg::OP_VAR_DIV:
            begin
                div_start = 1'b1;
                div_num   = {dev_reg, 8'd0};
                div_den   = DW'(wsum_reg - wrs_pkg::WSUM_ONE);
            end
            wrs_pkg::OP_QW_DIV:
            begin
                div_start = 1'b1;
                div_num   = NW'(wsq_reg);
                div_den   = DW'(wsum_reg);
            end
            wrs_pkg::OP_UNB_DIV:
            begin
                div_start = 1'b1;
                div_num   = {dev_reg, 8'd0};
                div_den   = DW'(wsum_reg - qw_reg[wrs_pkg::WSUM_W-1:0]);
            end
            wrs_pkg::OP_CV_DIV:
            begin
                div_start = 1'b1;
                div_num   = NW'({sd_reg, 16'd0});
                div_den   = DW'(mean_mag);
            end
            wrs_pkg::OP_HW_DIV:
            begin
                div_start = 1'b1;
                div_num   = NW'(hp_reg);
                div_den   = DW'(root_reg);
            end
            wrs_pkg::OP_SD_SQRT:
            begin
                sqrt_start = 1'b1;
                sqrt_arg   = {var_reg, 16'd0};
            end
            wrs_pkg::OP_RT_SQRT:
            begin
                sqrt_start = 1'b1;
                sqrt_arg   = wrs_pkg::SQRT_ARG_W'({count_reg, 16'd0});
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // statistics and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crit_reg      <= wrs_pkg::CRIT_RESET;
            count_reg     <= '0;
            min_reg       <= VAL_MAX;
            max_reg       <= VAL_MIN;
            wsum_reg      <= '0;
            wsq_reg       <= '0;
            mean_reg      <= '0;
            dev_reg       <= '0;
            clear_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            mbusy_reg     <= 1'b0;
            mdone_reg     <= 1'b0;
            mcnt_reg      <= '0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                crit_reg <= cfg_write_data;
            end
            if (op == wrs_pkg::OP_PUBLISH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            mdone_reg <= 1'b0;
            if (op == wrs_pkg::OP_MUL_START)
            begin
                mbusy_reg <= 1'b1;
                mcnt_reg  <= MCNT_W'(A_W);
            end
            else if (mbusy_reg)
            begin
                mcnt_reg <= mcnt_reg - 1'b1;
                if (mcnt_reg == MCNT_W'(1))
                begin
                    mbusy_reg <= 1'b0;
                    mdone_reg <= 1'b1;
                end
            end
            if (op == wrs_pkg::OP_LOAD)
            begin
                clear_reg <= load_clear;
                if (load_clear)
                begin
                    count_reg <= '0;
                    min_reg   <= VAL_MAX;
                    max_reg   <= VAL_MIN;
                    wsum_reg  <= '0;
                    wsq_reg   <= '0;
                    mean_reg  <= '0;
                    dev_reg   <= '0;
                end
                else
                begin
                    count_reg <= count_next;
                    wsum_reg  <= wsum_next;
                    wsq_reg   <= wsq_next;
                    if (sample_value < min_reg)
                    begin
                        min_reg <= sample_value;
                    end
                    if (sample_value > max_reg)
                    begin
                        max_reg <= sample_value;
                    end
                end
            end
            if (op == wrs_pkg::OP_MEAN_UPD)
            begin
                mean_reg <= mean_next;
            end
            if (op == wrs_pkg::OP_DEV_UPD)
            begin
                dev_reg <= dev_next;
            end
        end
    end

    // working and output payload registers
    always_ff @(posedge clk)
    begin
        if (mbusy_reg)
        begin
            prod_reg <= {mul_hi, prod_reg[A_W-1:1]};
        end
        unique case (op)
            wrs_pkg::OP_LOAD:
            begin
                x_reg      <= sample_value;
                w_reg      <= sample_weight;
                d1_neg_reg <= d1_next[VW];
                a_reg      <= a_next;
                var_reg    <= '0;
                unb_reg    <= '0;
                cv_reg     <= '0;
                hw_reg     <= '0;
            end
            wrs_pkg::OP_PREP:     u_reg   <= U_W'(a_reg) * U_W'(w_reg);
            wrs_pkg::OP_MUL_START:
            begin
                d2_neg_reg <= d2_next[VW];
                prod_reg   <= {{U_W{1'b0}}, b_next};
            end
            wrs_pkg::OP_VAR_WR:   var_reg  <= vq_next;
            wrs_pkg::OP_QW_WR:    qw_reg   <= div_quo;
            wrs_pkg::OP_UNB_WR:   unb_reg  <= vq_next;
            wrs_pkg::OP_SD_WR:    sd_reg   <= sqrt_res;
            wrs_pkg::OP_CV_WR:    cv_reg   <= cv_next;
            wrs_pkg::OP_RT_WR:    root_reg <= sqrt_res;
            wrs_pkg::OP_HW_MUL:
            begin
                hp_reg <= wrs_pkg::PROD_W'(crit_reg) * wrs_pkg::PROD_W'(sd_reg);
            end
            wrs_pkg::OP_HW_WR:    hw_reg   <= hw_next;
            wrs_pkg::OP_PUBLISH:
            begin
                o_count_reg <= count_reg;
                o_min_reg   <= (count_reg != '0) ? min_reg : '0;
                o_max_reg   <= (count_reg != '0) ? max_reg : '0;
                o_mean_reg  <= mean_reg;
                o_var_reg   <= var_reg;
                o_unb_reg   <= unb_reg;
                o_sd_reg    <= sd_reg;
                o_cv_reg    <= cv_reg;
                o_hw_reg    <= hw_reg;
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    always_comb
    begin
        status.is_clear    = clear_reg;
        status.wsum_nz     = wsum_reg != '0;
        status.wsum_gt_one = wsum_reg > wrs_pkg::WSUM_ONE;
        status.wsum_gt_q   = NW'(wsum_reg) > qw_reg;
        status.mean_nz     = mean_reg != '0;
        status.count_nz    = count_reg != '0;
        status.div_done    = div_done;
        status.sqrt_done   = sqrt_done;
        status.mul_done    = mdone_reg;
        status.out_full    = out_valid_reg && out_stall;
    end

    assign out_valid         = out_valid_reg;
    assign sample_count      = o_count_reg;
    assign min_value         = o_min_reg;
    assign max_value         = o_max_reg;
    assign mean_value        = o_mean_reg;
    assign variance_out      = o_var_reg;
    assign unbiased_variance = o_unb_reg;
    assign std_deviation     = o_sd_reg;
    assign variation_coef    = o_cv_reg;
    assign half_width        = o_hw_reg;

endmodule

@@ rtl/weighted_running_statistics_top.sv @@
// weighted running statistics: top level joining the sequencer and datapath
// depends on wrs_pkg, wrs_ctrl and wrs_datapath
//
// usage
// - input channel (in_valid / in_stall) carries one request: command 0 adds a
//   weighted sample (signed q16.16 value, unsigned q8.8 weight), command 1
//   clears every statistic
// - output channel (out_valid / out_stall) returns exactly one result per
//   request: count, min, max, mean, variance, unbiased variance, standard
//   deviation, coefficient of variation and confidence half-width
// - critical_value (q8.8) is written through cfg_write_enable / cfg_write_data
//   while no request is in progress; it resets to 502 and survives a clear
// - one request at a time: in_stall is high from acceptance until the result
//   is placed in the output register
// - an add, when no step is skipped, runs six quotients on the shared 72-bit
//   divider, two 32-bit square roots and a shift-add multiplier over a
//   value-width-plus-one bit operand, plus sequencing; steps whose denominator
//   would be zero or negative are skipped, so a clear runs only the
//   standard deviation square root
// - the output register lets the next request be accepted while a result
//   waits; if the receiver stalls, the result holds and the following request
//   waits in its final step until the register frees
// - reset (rst_n, asynchronous, active low) empties the statistics, restores
//   the critical value and drops any pending result
module weighted_running_statistics_top
#(
    parameter int COUNT_WIDTH = 24,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_enable,
    input  logic [wrs_pkg::CRIT_W-1:0]      cfg_write_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            command,
    input  logic signed [VALUE_WIDTH-1:0]   sample_value,
    input  logic [wrs_pkg::WEIGHT_W-1:0]    sample_weight,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [COUNT_WIDTH-1:0]          sample_count,
    output logic signed [VALUE_WIDTH-1:0]   min_value,
    output logic signed [VALUE_WIDTH-1:0]   max_value,
    output logic signed [VALUE_WIDTH-1:0]   mean_value,
    output logic [wrs_pkg::VAR_W-1:0]       variance_out,
    output logic [wrs_pkg::VAR_W-1:0]       unbiased_variance,
    output logic [wrs_pkg::SD_W-1:0]        std_deviation,
    output logic signed [wrs_pkg::CV_W-1:0] variation_coef,
    output logic [wrs_pkg::HW_W-1:0]        half_width
);

    // operation code from the sequencer, status flags back from the datapath
    wrs_pkg::dp_op_t     op;
    wrs_pkg::dp_status_t status;

    wrs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .op       (op)
    );

    // statistics state, shared divider and square root, output register
    wrs_datapath
    #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    )
    u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .op                (op),
        .status            (status),
        .cfg_write_enable  (cfg_write_enable),
        .cfg_write_data    (cfg_write_data),
        .command           (command),
        .sample_value      (sample_value),
        .sample_weight     (sample_weight),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .sample_count      (sample_count),
        .min_value         (min_value),
        .max_value         (max_value),
        .mean_value        (mean_value),
        .variance_out      (variance_out),
        .unbiased_variance (unbiased_variance),
        .std_deviation     (std_deviation),
        .variation_coef    (variation_coef),
        .half_width        (half_width)
    );

endmodule

@@ rtl/wrs_checker.sv @@
// port-level checks of the statistics block and their binding to the top level
// depends on wrs_pkg and weighted_running_statistics_top
module wrs_checker
#(
    parameter int COUNT_WIDTH = 24,
    parameter int VALUE_WIDTH = 32
)
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [COUNT_WIDTH-1:0]          sample_count,
    input logic signed [VALUE_WIDTH-1:0]   min_value,
    input logic signed [VALUE_WIDTH-1:0]   max_value,
    input logic [wrs_pkg::VAR_W-1:0]       variance_out,
    input logic [wrs_pkg::SD_W-1:0]        std_deviation,
    input logic signed [wrs_pkg::CV_W-1:0] variation_coef,
    input logic [wrs_pkg::HW_W-1:0]        half_width
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled result withdrawn");

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while busy");

    // empty statistics report no extremes and no interval
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (sample_count == '0) |->
            (min_value == '0) && (max_value == '0) && (half_width == '0))
        else $error("empty result not zero");

    // zero variance gives zero deviation figures
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (variance_out == '0) |->
            (std_deviation == '0) && (variation_coef == '0) && (half_width == '0))
        else $error("deviation without variance");

endmodule

bind weighted_running_statistics_top wrs_checker
#(
    .COUNT_WIDTH (COUNT_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
)
u_wrs_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sample_count   (sample_count),
    .min_value      (min_value),
    .max_value      (max_value),
    .variance_out   (variance_out),
    .std_deviation  (std_deviation),
    .variation_coef (variation_coef),
    .half_width     (half_width)
);

@@ dv/wrs_stats_checker.sv @@
// result checker for weighted_running_statistics_top: predicts every result from accepted requests
// and configuration writes, then compares each accepted result field by field
// depends on wrs_pkg
`timescale 1ns / 100ps

module wrs_stats_checker
    import wrs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write_enable,
    input  logic [CRIT_W-1:0]        cfg_write_data,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic                     command,
    input  logic signed [31:0]       sample_value,
    input  logic [WEIGHT_W-1:0]      sample_weight,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [23:0]              sample_count,
    input  logic signed [31:0]       min_value,
    input  logic signed [31:0]       max_value,
    input  logic signed [31:0]       mean_value,
    input  logic [VAR_W-1:0]         variance_out,
    input  logic [VAR_W-1:0]         unbiased_variance,
    input  logic [SD_W-1:0]          std_deviation,
    input  logic signed [CV_W-1:0]   variation_coef,
    input  logic [HW_W-1:0]          half_width,
    output int                       fail_count,
    output int                       results_owed
);

    typedef struct packed {
        logic [23:0]       cnt;
        logic [31:0]       mn;
        logic [31:0]       mx;
        logic [31:0]       mean;
        logic [VAR_W-1:0]  var_v;
        logic [VAR_W-1:0]  unb;
        logic [SD_W-1:0]   sd;
        logic [CV_W-1:0]   cv;
        logic [HW_W-1:0]   hw;
    } stats_result_t;

    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;

    stats_result_t stats_owed[$];

    bit [15:0]   crit;
    bit [23:0]   n_samples;
    longint      lo_sample;
    longint      hi_sample;
    bit [63:0]   w_total;
    bit [63:0]   w_sq_total;
    longint      run_mean;
    bit [63:0]   dev_total;

    function automatic bit [63:0] floor_root(bit [63:0] v);
        bit [63:0] res = 0;
        bit [63:0] b = 64'h4000_0000_0000_0000;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // floor(num * 256 / den) saturated to 48 bits
    function automatic bit [63:0] ratio_q8(bit [63:0] num, bit [63:0] den);
        bit [127:0] q;
        q = {num, 8'd0} / den;
        return (q > 128'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : q[63:0];
    endfunction

    function automatic bit [63:0] magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    task automatic clear_stats();
        n_samples  = 0;
        lo_sample  = VMAX;
        hi_sample  = VMIN;
        w_total    = 0;
        w_sq_total = 0;
        run_mean   = 0;
        dev_total  = 0;
    endtask

    task automatic fold_sample(longint x, bit [63:0] w);
        longint     old_mean;
        longint     d1;
        longint     d2;
        bit [63:0]  a;
        bit [127:0] prod;
        bit [63:0]  term;
        bit [64:0]  acc;
        old_mean = run_mean;
        if (n_samples != 24'hFF_FFFF)
            n_samples++;
        if (x < lo_sample)
            lo_sample = x;
        if (x > hi_sample)
            hi_sample = x;
        w_total = w_total + w;
        if (w_total > 64'hFF_FFFF_FFFF)
            w_total = 64'hFF_FFFF_FFFF;
        w_sq_total = w_sq_total + w * w;
        if (w_sq_total > 64'hFF_FFFF_FFFF_FFFF)
            w_sq_total = 64'hFF_FFFF_FFFF_FFFF;
        d1 = x - old_mean;
        a = magnitude(d1);
        if (w_total != 0)
        begin
            run_mean = (d1 < 0) ? old_mean - longint'((a * w) / w_total)
                                : old_mean + longint'((a * w) / w_total);
            if (run_mean > VMAX)
                run_mean = VMAX;
            if (run_mean < VMIN)
                run_mean = VMIN;
        end
        d2 = x - run_mean;
        prod = 128'(a * w) * 128'(magnitude(d2));
        term = (prod[127:88] != 0) ? '1 : prod[87:24];
        if (((d1 < 0) != (d2 < 0)) && term != 0)
            dev_total = (dev_total > term) ? dev_total - term : 0;
        else
        begin
            acc = 65'(dev_total) + 65'(term);
            dev_total = acc[64] ? '1 : acc[63:0];
        end
    endtask

    function automatic stats_result_t derive_stats();
        stats_result_t r;
        bit [63:0] var_v = 0;
        bit [63:0] unb = 0;
        bit [63:0] sd;
        bit [63:0] q;
        bit [63:0] c;
        bit [63:0] hw = 0;
        bit [63:0] cv = 0;
        if (w_total > 256)
            var_v = ratio_q8(dev_total, w_total - 256);
        if (w_total != 0)
        begin
            q = w_sq_total / w_total;
            if (w_total > q)
                unb = ratio_q8(dev_total, w_total - q);
        end
        sd = floor_root(var_v << 16);
        if (run_mean != 0)
        begin
            c = (sd << 16) / magnitude(run_mean);
            if (run_mean > 0)
                cv = (c > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : c;
            else
                cv = -((c > 64'h8000_0000) ? 64'h8000_0000 : c);
        end
        if (n_samples != 0)
        begin
            hw = (64'(crit) * sd) / floor_root(64'(n_samples) << 16);
            if (hw > 64'hFFFF_FFFF)
                hw = 64'hFFFF_FFFF;
        end
        r.cnt   = n_samples;
        r.mn    = (n_samples != 0) ? lo_sample[31:0] : '0;
        r.mx    = (n_samples != 0) ? hi_sample[31:0] : '0;
        r.mean  = run_mean[31:0];
        r.var_v = var_v[VAR_W-1:0];
        r.unb   = unb[VAR_W-1:0];
        r.sd    = sd[SD_W-1:0];
        r.cv    = cv[CV_W-1:0];
        r.hw    = hw[HW_W-1:0];
        return r;
    endfunction

    task automatic report(string what, logic [63:0] want, logic [63:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t mismatch %s: expected %h actual %h", $realtime, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stats_result_t want;
        if (!rst_n)
        begin
            crit = CRIT_RESET;
            clear_stats();
            stats_owed.delete();
            fail_count   = 0;
            results_owed = 0;
        end
        else
        begin
            if (cfg_write_enable)
                crit = cfg_write_data;
            if (out_valid && !out_stall)
            begin
                if (stats_owed.size() == 0)
                    report("unexpected result", 0, 1);
                else
                begin
                    want = stats_owed.pop_front();
                    if (sample_count !== want.cnt)
                        report("sample_count", want.cnt, sample_count);
                    if (min_value !== want.mn)
                        report("min_value", want.mn, min_value);
                    if (max_value !== want.mx)
                        report("max_value", want.mx, max_value);
                    if (mean_value !== want.mean)
                        report("mean_value", want.mean, mean_value);
                    if (variance_out !== want.var_v)
                        report("variance_out", want.var_v, variance_out);
                    if (unbiased_variance !== want.unb)
                        report("unbiased_variance", want.unb, unbiased_variance);
                    if (std_deviation !== want.sd)
                        report("std_deviation", want.sd, std_deviation);
                    if (variation_coef !== want.cv)
                        report("variation_coef", want.cv, variation_coef);
                    if (half_width !== want.hw)
                        report("half_width", want.hw, half_width);
                end
            end
            if (in_valid && !in_stall)
            begin
                if (command == CMD_CLEAR)
                    clear_stats();
                else
                    fold_sample(longint'(sample_value), 64'(sample_weight));
                stats_owed.push_back(derive_stats());
            end
            results_owed = stats_owed.size();
        end
    end

endmodule

@@ dv/weighted_running_statistics_top_tb.sv @@
// testbench top for weighted_running_statistics_top: clock, reset, request stimulus,
// result stall pattern and verdict
// depends on wrs_pkg, weighted_running_statistics_top and wrs_stats_checker
`timescale 1ns / 100ps

module weighted_running_statistics_top_tb;
    import wrs_pkg::*;

    localparam int LIMIT_CYCLES = 6000000;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write_enable;
    logic [CRIT_W-1:0]        cfg_write_data;
    logic                     in_valid;
    logic                     in_stall;
    logic                     command;
    logic signed [31:0]       sample_value;
    logic [WEIGHT_W-1:0]      sample_weight;
    logic                     out_valid;
    logic                     out_stall;
    logic [23:0]              sample_count;
    logic signed [31:0]       min_value;
    logic signed [31:0]       max_value;
    logic signed [31:0]       mean_value;
    logic [VAR_W-1:0]         variance_out;
    logic [VAR_W-1:0]         unbiased_variance;
    logic [SD_W-1:0]          std_deviation;
    logic signed [CV_W-1:0]   variation_coef;
    logic [HW_W-1:0]          half_width;
    int                       fail_count;
    int                       results_owed;
    int                       cycle_count = 0;
    int                       stall_left;
    logic                     stall_mode;

    weighted_running_statistics_top u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_enable  (cfg_write_enable),
        .cfg_write_data    (cfg_write_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .command           (command),
        .sample_value      (sample_value),
        .sample_weight     (sample_weight),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .sample_count      (sample_count),
        .min_value         (min_value),
        .max_value         (max_value),
        .mean_value        (mean_value),
        .variance_out      (variance_out),
        .unbiased_variance (unbiased_variance),
        .std_deviation     (std_deviation),
        .variation_coef    (variation_coef),
        .half_width        (half_width)
    );

    wrs_stats_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_enable  (cfg_write_enable),
        .cfg_write_data    (cfg_write_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .command           (command),
        .sample_value      (sample_value),
        .sample_weight     (sample_weight),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .sample_count      (sample_count),
        .min_value         (min_value),
        .max_value         (max_value),
        .mean_value        (mean_value),
        .variance_out      (variance_out),
        .unbiased_variance (unbiased_variance),
        .std_deviation     (std_deviation),
        .variation_coef    (variation_coef),
        .half_width        (half_width),
        .fail_count        (fail_count),
        .results_owed      (results_owed)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 120);
    endfunction

    // receiver side: stall runs and free runs of random length, with stall-free stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            stall_mode <= 1'b0;
        end
        else if (stall_left == 0)
        begin
            stall_mode <= ($urandom_range(0, 2) == 0);
            stall_left <= pick_gap() * 8 + 1;
            out_stall  <= 1'b0;
        end
        else
        begin
            stall_left <= stall_left - 1;
            out_stall  <= stall_mode && ($urandom_range(0, 3) != 0);
        end
    end

    // hard stop on a hung block
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("weighted_running_statistics_top verification failed");
            $finish;
        end
    end

    // hold one request until the block takes it; stall only moves at the rising edge,
    // so a low stall seen at the falling edge means acceptance at the next rising edge
    task automatic send_request(logic cmd, logic [31:0] value, logic [15:0] weight);
        int gap;
        command       <= cmd;
        sample_value  <= value;
        sample_weight <= weight;
        in_valid      <= 1'b1;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // register writes only once every result is back and the block is quiet
    task automatic write_critical(logic [15:0] value);
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_owed != 0 || in_stall)
            @(negedge clk);
        @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= value;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
    endtask

    // random request: a clear now and then, else small values and weights mostly, full range sometimes
    task automatic random_request();
        logic [31:0] value;
        logic [15:0] weight;
        int          roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            send_request(CMD_CLEAR, $urandom, 16'($urandom));
            return;
        end
        case ($urandom_range(0, 3))
            0: value = $urandom;
            1: value = 32'($urandom_range(0, 2000000)) - 32'd1000000;
            2: value = 32'($urandom_range(0, 40000000)) - 32'd20000000;
            default: value = {{8{1'b0}}, 24'($urandom)} + 32'h0010_0000;
        endcase
        case ($urandom_range(0, 4))
            0: weight = 16'($urandom);
            1: weight = 16'd256;
            2: weight = 16'($urandom_range(0, 8));
            default: weight = 16'($urandom_range(1, 1024));
        endcase
        send_request(CMD_ADD, value, weight);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_write_data   = '0;
        in_valid         = 1'b0;
        command          = CMD_ADD;
        sample_value     = '0;
        sample_weight    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty clear, zero weight first, unit weight, extremes, clears
        send_request(CMD_CLEAR, 32'h0, 16'h0);
        send_request(CMD_ADD, 32'h0001_0000, 16'h0000);
        send_request(CMD_ADD, 32'h0002_0000, 16'h0100);
        send_request(CMD_ADD, 32'h0004_0000, 16'h0100);
        send_request(CMD_ADD, 32'h7FFF_FFFF, 16'hFFFF);
        send_request(CMD_ADD, 32'h8000_0000, 16'hFFFF);
        send_request(CMD_ADD, 32'hFFFF_FFFF, 16'h0001);
        send_request(CMD_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(CMD_ADD, 32'hFFF0_0000, 16'h0080);
        send_request(CMD_ADD, 32'hFFE0_0000, 16'h0080);
        send_request(CMD_ADD, 32'hFFC0_0000, 16'h0300);
        send_request(CMD_CLEAR, 32'h0, 16'h0);
        send_request(CMD_ADD, 32'h8000_0000, 16'h0100);
        send_request(CMD_ADD, 32'h7FFF_FFFF, 16'h0100);
        send_request(CMD_ADD, 32'h0000_0000, 16'hFFFF);
        send_request(CMD_ADD, 32'h0000_0000, 16'hFFFF);
        send_request(CMD_ADD, 32'h5555_5555, 16'hAAAA);
        send_request(CMD_ADD, 32'hAAAA_AAAA, 16'h5555);
        send_request(CMD_CLEAR, 32'h0, 16'h0);

        // random phases, each under its own critical value including both extremes
        write_critical(16'hFFFF);
        repeat (380) random_request();
        write_critical(16'h0000);
        repeat (380) random_request();
        write_critical(16'($urandom));
        repeat (380) random_request();
        write_critical(CRIT_RESET);
        repeat (380) random_request();

        in_valid <= 1'b0;
        @(negedge clk);
        while (results_owed != 0)
            @(negedge clk);
        repeat (600) @(posedge clk);
        if (fail_count == 0)
            $display("weighted_running_statistics_top verification clean");
        else
            $display("weighted_running_statistics_top verification failed");
        $finish;
    end

endmodule
